### src/mhpq_pkg.sv
// shared codes and control types for the max-heap priority queue
`default_nettype none

package mhpq_pkg;

  // operation codes carried in the op field
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  // per-beat command broadcast along the cell row
  typedef struct packed {
    logic push;
    logic pop;
  } mhpq_ctrl_t;

endpackage

`default_nettype wire

### src/mhpq_cell.sv
// one slot of the sorted cell row: holds a value, inserts or shifts on command
`default_nettype none

module mhpq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                          clk,
  input  wire mhpq_pkg::mhpq_ctrl_t    ctrl,
  input  wire logic [DATA_WIDTH-1:0]   ins_val,
  input  wire logic [DATA_WIDTH-1:0]   left_val,
  input  wire logic                    left_lt,
  input  wire logic [DATA_WIDTH-1:0]   right_val,
  input  wire logic                    vacant,
  output logic      [DATA_WIDTH-1:0]   val,
  output logic                         lt
);

  import mhpq_pkg::*;

  // a vacant slot counts as smaller than anything being inserted
  assign lt = vacant || ($signed(val) < $signed(ins_val));

  // insert: slots below the new value shift right by one, the first one takes it
  // pop: every slot takes its right neighbor
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (lt) begin
        val <= left_lt ? left_val : ins_val;
      end
    end else if (ctrl.pop) begin
      val <= right_val;
    end
  end

endmodule

`default_nettype wire

### src/max_heap_priority_queue_unit.sv
// top level of the max priority queue built as a row of sorted cells
`default_nettype none

// Max priority queue of signed DATA_WIDTH-bit values, up to DEPTH entries.
// Entries sit in a row of DEPTH cells kept in descending order; a push makes
// every cell compare its value with the new one in parallel and the smaller
// ones move one place right, a pop moves every cell one place left and hands
// out the front cell. The result of each beat is registered at
// the edge that accepts the beat and shows on the output the cycle after, and
// a new beat is accepted in every cycle in which the output register is empty
// or being drained. The critical path is one signed compare in a cell plus the
// select from its left neighbor. After reset the queue is empty and usable at
// once. A push while full returns overflow and drops the value; a pop while
// empty returns underflow with a zero value.
module max_heap_priority_queue_unit #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire logic                            op,
  input  wire logic signed [DATA_WIDTH-1:0]    value,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [DATA_WIDTH-1:0]         popped_value,
  output logic        [1:0]                    status,
  output logic        [$clog2(DEPTH+1)-1:0]    count_after
);

  import mhpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  accept;
  logic                  push_ok;
  logic                  pop_ok;
  logic                  full;
  logic                  empty;
  mhpq_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]      cell_lt;
  logic [DEPTH-1:0]      vacant;

  // handshake and command decode
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign push_ok  = accept && (op == OP_PUSH) && !full;
  assign pop_ok   = accept && (op == OP_POP) && !empty;
  assign ctrl     = '{push: push_ok, pop: pop_ok};

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val;
    logic                  left_lt;
    logic [DATA_WIDTH-1:0] right_val;

    assign vacant[g] = (CNT_W'(g) >= count);

    if (g == 0) begin : g_head
      assign left_val = '0;
      assign left_lt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[g-1];
      assign left_lt  = cell_lt[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_body
      assign right_val = cell_val[g+1];
    end

    mhpq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ins_val   (value),
      .left_val  (left_val),
      .left_lt   (left_lt),
      .right_val (right_val),
      .vacant    (vacant[g]),
      .val       (cell_val[g]),
      .lt        (cell_lt[g])
    );
  end

  // entry count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= pop_ok ? cell_val[0] : '0;
      count_after  <= count_next;
      if (op == OP_PUSH) begin
        status <= full ? STATUS_OVERFLOW : STATUS_OK;
      end else begin
        status <= empty ? STATUS_UNDERFLOW : STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

### src/mhpq_checker.sv
// port-level checks for the max priority queue and their binding
`default_nettype none

module mhpq_checker #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire logic                         op,
  input wire logic [DATA_WIDTH-1:0]        value,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire logic [DATA_WIDTH-1:0]        popped_value,
  input wire logic [1:0]                   status,
  input wire logic [$clog2(DEPTH+1)-1:0]   count_after
);

  import mhpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // a result beat that is held back keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(popped_value) &&
      $stable(status) && $stable(count_after))
    else $error("result beat changed while stalled");

  // an empty output register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // underflow leaves an empty queue and no value
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_UNDERFLOW |-> popped_value == '0 && count_after == '0)
    else $error("underflow beat with value or entries");

  // overflow only with a full queue and no value
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OVERFLOW |->
      popped_value == '0 && count_after == CNT_W'(DEPTH))
    else $error("overflow beat while not full");

  // a new result only follows an accepted input beat
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result beat without an input beat");

  // op and value are observed only through the handshake
  logic unused_in;
  assign unused_in = op ^ (^value);

endmodule

bind max_heap_priority_queue_unit mhpq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .op           (op),
  .value        (value),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .popped_value (popped_value),
  .status       (status),
  .count_after  (count_after)
);

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the max priority queue: heap predictor, scoreboard, random traffic
module testbench;
  import mhpq_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int DATA_WIDTH  = 32;
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  typedef logic signed [DATA_WIDTH-1:0] heap_word_t;

  // one expected result beat
  typedef struct {
    heap_word_t         pop_val;
    logic [1:0]         code;
    logic [COUNT_W-1:0] held;
  } heap_result_t;

  // mirrors the queue contents as a binary max-heap and holds pending results
  class max_heap_tracker;
    heap_word_t   heap_mirror [DEPTH];
    int unsigned  held_count;
    heap_result_t expected_results [$];
    int unsigned  mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      heap_word_t t;
      t = heap_mirror[a];
      heap_mirror[a] = heap_mirror[b];
      heap_mirror[b] = t;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // apply one accepted operation to the mirror and queue its result
    function void note_beat(logic beat_op, heap_word_t beat_value);
      heap_result_t res;
      int unsigned  pos;
      int unsigned  parent;
      int unsigned  left;
      int unsigned  right;
      int unsigned  best;
      bit           moving;
      res.pop_val = '0;
      res.code    = STATUS_OK;
      if (beat_op == OP_PUSH) begin
        if (held_count >= DEPTH) begin
          res.code = STATUS_OVERFLOW;
        end else begin
          // append, then sift up while the parent is strictly smaller
          pos = held_count;
          heap_mirror[pos] = beat_value;
          held_count++;
          moving = 1'b1;
          while (moving && pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_mirror[parent] < heap_mirror[pos]) begin
              swap_slots(parent, pos);
              pos = parent;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end else begin
        if (held_count == 0) begin
          res.code = STATUS_UNDERFLOW;
        end else begin
          // take root, move last entry up, sift down toward the larger child
          res.pop_val = heap_mirror[0];
          heap_mirror[0] = heap_mirror[held_count - 1];
          held_count--;
          pos = 0;
          moving = 1'b1;
          while (moving) begin
            left  = 2 * pos + 1;
            right = 2 * pos + 2;
            best  = pos;
            if (left < held_count && heap_mirror[best] < heap_mirror[left]) best = left;
            if (right < held_count && heap_mirror[best] < heap_mirror[right]) best = right;
            if (best == pos) begin
              moving = 1'b0;
            end else begin
              swap_slots(pos, best);
              pos = best;
            end
          end
        end
      end
      res.held = COUNT_W'(held_count);
      expected_results.push_back(res);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_beat(heap_word_t got_val, logic [1:0] got_code,
                             logic [COUNT_W-1:0] got_held);
      heap_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing outstanding: popped_value %0d status %0d count_after %0d",
               got_val, got_code, got_held);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got_val !== want.pop_val) begin
        $error("popped_value: expected %0d, actual %0d", want.pop_val, got_val);
        mismatches++;
      end
      if (got_code !== want.code) begin
        $error("status: expected %0d, actual %0d", want.code, got_code);
        mismatches++;
      end
      if (got_held !== want.held) begin
        $error("count_after: expected %0d, actual %0d", want.held, got_held);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = OP_PUSH;
  heap_word_t         value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  heap_word_t         popped_value;
  logic [1:0]         status;
  logic [COUNT_W-1:0] count_after;

  int unsigned     send_idle_pct = 38;
  int unsigned     recv_idle_pct = 46;
  int unsigned     cycle_count = 0;
  max_heap_tracker tracker;

  max_heap_priority_queue_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .status       (status),
    .count_after  (count_after)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_beat(popped_value, status, count_after);
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // mostly full-range values, with extremes and a narrow band for ties
  function automatic heap_word_t pick_value();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
          1: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
          2: return '0;
          default: return '1;
        endcase
      end
      1: return heap_word_t'($signed($urandom_range(8)) - 4);
      default: return heap_word_t'($urandom);
    endcase
  endfunction

  function automatic logic pick_op(int unsigned push_pct);
    return ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
  endfunction

  // present one operation beat, with random gaps ahead of it
  task automatic send_beat(input logic beat_op, input heap_word_t beat_value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= beat_op;
    value    <= beat_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_beat(beat_op, beat_value);
  endtask

  // hold the sender off until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    heap_word_t directed_values [9];
    directed_values = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001,
      32'sh0000_0005, 32'sh0000_0005, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, extremes and a tie, drain to empty, empty pop again
    send_beat(OP_POP, heap_word_t'($urandom));
    foreach (directed_values[k]) send_beat(OP_PUSH, directed_values[k]);
    repeat (10) send_beat(OP_POP, heap_word_t'($urandom));

    // balanced traffic around an empty queue
    repeat (50) send_beat(pick_op(55), pick_value());
    wait_drained();

    // swap idling, fill to capacity, then work at the full boundary
    send_idle_pct = 46;
    recv_idle_pct = 38;
    while (tracker.held_count < DEPTH) send_beat(pick_op(98), pick_value());
    repeat (30) send_beat(pick_op(60), pick_value());

    // no idling: pop-leaning traffic from near full
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (30) send_beat(pick_op(40), pick_value());

    // let all results come back
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
